// ===== sv/vector3_fixed_point_alu_defines.svh =====
// Assertion macros for the vector ALU; they sample on clk and are disabled while rst_n is low.
`ifndef VECTOR3_FIXED_POINT_ALU_DEFINES_SVH
`define VECTOR3_FIXED_POINT_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define V3A_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("v3alu: implication check failed");
`define V3A_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("v3alu: latency check failed");
`else
`define V3A_ASSERT_IMP(lbl, ante, cons)
`define V3A_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

// ===== sv/v3alu_pkg.sv =====
`default_nettype none
package v3alu_pkg;

  localparam int SQ_CELLS = 32;
  localparam int QMAX     = 25;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_CROSS = 3'd3,
    OP_SCALE = 3'd4,
    OP_NORM  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0]            divisor;
    logic [2:0][31:0]       rem;
    logic [2:0][QMAX-1:0]   quo;
    logic [2:0]             nb;
  } div_t;

  typedef struct packed {
    op_t              op;
    logic [2:0][31:0] r;
    logic             sat;
    logic [2:0][31:0] amag;
    logic [2:0]       asgn;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic             sat;
    logic             valid;
    logic             zn;
  } res_t;

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== sv/v3alu_sqrt_cell.sv =====
`default_nettype none
module v3alu_sqrt_cell (
  input  logic            clk,
  input  v3alu_pkg::sq_t  d_i,
  output v3alu_pkg::sq_t  q_o
);
  import v3alu_pkg::*;

  logic [35:0] sh;
  logic [35:0] trial;
  sq_t         q_nxt;
  sq_t         q_r;

  always_comb begin
    sh        = {d_i.rem, d_i.n[63:62]};
    trial     = {2'b00, d_i.root, 2'b01};
    q_nxt.n   = {d_i.n[61:0], 2'b00};
    if (sh >= trial) begin
      q_nxt.rem  = 34'(sh - trial);
      q_nxt.root = {d_i.root[30:0], 1'b1};
    end else begin
      q_nxt.rem  = sh[33:0];
      q_nxt.root = {d_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;
endmodule
`default_nettype wire

// ===== sv/v3alu_div_cell.sv =====
`default_nettype none
module v3alu_div_cell (
  input  logic             clk,
  input  v3alu_pkg::div_t  d_i,
  output v3alu_pkg::div_t  q_o
);
  import v3alu_pkg::*;

  logic [32:0] sh [3];
  div_t        q_nxt;
  div_t        q_r;

  always_comb begin
    q_nxt.divisor = d_i.divisor;
    q_nxt.nb      = '0;
    for (int i = 0; i < 3; i++) begin
      sh[i] = {d_i.rem[i], d_i.nb[i]};
      if (sh[i] >= {1'b0, d_i.divisor}) begin
        q_nxt.rem[i] = 32'(sh[i] - {1'b0, d_i.divisor});
        q_nxt.quo[i] = {d_i.quo[i][QMAX-2:0], 1'b1};
      end else begin
        q_nxt.rem[i] = sh[i][31:0];
        q_nxt.quo[i] = {d_i.quo[i][QMAX-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;
endmodule
`default_nettype wire

// ===== sv/vector3_fixed_point_alu.sv =====
// Three-component vector ALU in signed fixed point, fully pipelined: busy stays low and a
// new transaction may start in every cycle. Each transaction yields exactly one result,
// shown for one cycle with out_valid high. The pipeline holds two chains of 32 square-root
// cells (one for the normalize divisor, one for the result length) and a chain of
// FRAC_BITS+1 divider cells. The receiver cannot stall the output.
`default_nettype none
`include "vector3_fixed_point_alu_defines.svh"
module vector3_fixed_point_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by_comp,
  input  logic signed [31:0] in_bz,
  input  logic signed [31:0] in_scale_factor,
  output logic               out_valid,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic signed [31:0] out_rz,
  output logic [30:0]        out_length,
  output logic [1:0]         out_status
);
  import v3alu_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int LAT = 2 * SQ_CELLS + QW + 7;

  logic [LAT-1:0] vld_r;

  op_t                op_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];
  logic signed [31:0] s_r;

  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic signed [63:0] p_r [6];
  op_t                opa_r;
  logic signed [31:0] aa_r [3];
  logic signed [31:0] ba_r [3];

  logic signed [65:0] wide [3];
  logic [32:0]        satv [3];
  side_t              side_nxt;
  side_t              side_r;
  logic [63:0]        ssq_nxt;
  logic [63:0]        ssq_r;

  side_t              sd_r [SQ_CELLS+QW];
  sq_t                sq1 [SQ_CELLS+1];
  div_t               dv [QW+1];

  res_t               c_nxt;
  res_t               c_r;
  logic signed [63:0] dp_r [3];
  res_t               d_r;
  logic [63:0]        ssq2_r;
  res_t               e_r;
  res_t               s2_r [SQ_CELLS];
  sq_t                sq2 [SQ_CELLS+1];

  logic [31:0]        q32 [3];
  logic [31:0]        root2;
  logic               len_sat;
  res_t               fin;

  logic signed [31:0] rx_r;
  logic signed [31:0] ry_r;
  logic signed [31:0] rz_r;
  logic [30:0]        len_r;
  status_t            st_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= op_t'(in_operation);
      a_r[0] <= in_ax;
      a_r[1] <= in_ay;
      a_r[2] <= in_az;
      b_r[0] <= in_bx;
      b_r[1] <= in_by_comp;
      b_r[2] <= in_bz;
      s_r    <= in_scale_factor;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    unique case (op_r)
      OP_CROSS: begin
        ma[0] = a_r[1]; mb[0] = b_r[2];
        ma[1] = a_r[2]; mb[1] = b_r[1];
        ma[2] = a_r[2]; mb[2] = b_r[0];
        ma[3] = a_r[0]; mb[3] = b_r[2];
        ma[4] = a_r[0]; mb[4] = b_r[1];
        ma[5] = a_r[1]; mb[5] = b_r[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a_r[i];
          mb[i] = s_r;
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a_r[i];
          mb[i] = a_r[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      p_r[i] <= ma[i] * mb[i];
    end
    opa_r <= op_r;
    for (int i = 0; i < 3; i++) begin
      aa_r[i] <= a_r[i];
      ba_r[i] <= b_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = '0;
    end
    unique case (opa_r)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          wide[i] = 66'(aa_r[i]) + 66'(ba_r[i]);
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          wide[i] = 66'(aa_r[i]) - 66'(ba_r[i]);
        end
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          wide[i] = -66'(aa_r[i]);
        end
      end
      OP_CROSS: begin
        wide[0] = (66'(p_r[0]) - 66'(p_r[1])) >>> FRAC_BITS;
        wide[1] = (66'(p_r[2]) - 66'(p_r[3])) >>> FRAC_BITS;
        wide[2] = (66'(p_r[4]) - 66'(p_r[5])) >>> FRAC_BITS;
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          wide[i] = 66'(p_r[i]) >>> FRAC_BITS;
        end
      end
      default: begin
      end
    endcase
    side_nxt.op  = opa_r;
    side_nxt.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      satv[i]          = sat32(wide[i]);
      side_nxt.r[i]    = satv[i][31:0];
      side_nxt.sat     = side_nxt.sat | satv[i][32];
      side_nxt.asgn[i] = aa_r[i][31];
      side_nxt.amag[i] = aa_r[i][31] ? $unsigned(-aa_r[i]) : $unsigned(aa_r[i]);
    end
    ssq_nxt = $unsigned(p_r[0]) + $unsigned(p_r[1]) + $unsigned(p_r[2]);
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    ssq_r  <= ssq_nxt;
    sd_r[0] <= side_r;
    for (int k = 1; k < SQ_CELLS + QW; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
  end

  assign sq1[0] = '{n: ssq_r, rem: '0, root: '0};

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq1
    v3alu_sqrt_cell u_cell (.clk(clk), .d_i(sq1[k]), .q_o(sq1[k+1]));
  end

  always_comb begin
    dv[0].divisor = sq1[SQ_CELLS].root;
    dv[0].quo     = '0;
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = {1'b0, sd_r[SQ_CELLS-1].amag[i][31:1]};
      dv[0].nb[i]  = sd_r[SQ_CELLS-1].amag[i][0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    v3alu_div_cell u_cell (.clk(clk), .d_i(dv[k]), .q_o(dv[k+1]));
  end

  always_comb begin
    c_nxt.r     = sd_r[SQ_CELLS+QW-1].r;
    c_nxt.sat   = sd_r[SQ_CELLS+QW-1].sat;
    c_nxt.valid = 1'b1;
    c_nxt.zn    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q32[i] = 32'(dv[QW].quo[i]);
    end
    unique case (sd_r[SQ_CELLS+QW-1].op) inside
      OP_NORM: begin
        c_nxt.sat = 1'b0;
        if (dv[QW].divisor == '0) begin
          c_nxt.r     = '0;
          c_nxt.valid = 1'b0;
          c_nxt.zn    = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            c_nxt.r[i] = sd_r[SQ_CELLS+QW-1].asgn[i] ? -q32[i] : q32[i];
          end
        end
      end
      OP_ADD, OP_SUB, OP_NEG, OP_CROSS, OP_SCALE: begin
      end
      default: begin
        c_nxt.r     = '0;
        c_nxt.sat   = 1'b0;
        c_nxt.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    for (int i = 0; i < 3; i++) begin
      dp_r[i] <= $signed(c_r.r[i]) * $signed(c_r.r[i]);
    end
    d_r    <= c_r;
    ssq2_r <= $unsigned(dp_r[0]) + $unsigned(dp_r[1]) + $unsigned(dp_r[2]);
    e_r    <= d_r;
    s2_r[0] <= e_r;
    for (int k = 1; k < SQ_CELLS; k++) begin
      s2_r[k] <= s2_r[k-1];
    end
  end

  assign sq2[0] = '{n: ssq2_r, rem: '0, root: '0};

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq2
    v3alu_sqrt_cell u_cell (.clk(clk), .d_i(sq2[k]), .q_o(sq2[k+1]));
  end

  assign fin     = s2_r[SQ_CELLS-1];
  assign root2   = sq2[SQ_CELLS].root;
  assign len_sat = fin.valid & root2[31];

  always_ff @(posedge clk) begin
    rx_r <= $signed(fin.r[0]);
    ry_r <= $signed(fin.r[1]);
    rz_r <= $signed(fin.r[2]);
    if (!fin.valid) begin
      len_r <= '0;
    end else if (root2[31]) begin
      len_r <= '1;
    end else begin
      len_r <= root2[30:0];
    end
    if (fin.zn) begin
      st_r <= ST_ZERO;
    end else if (fin.valid && (fin.sat || len_sat)) begin
      st_r <= ST_SAT;
    end else begin
      st_r <= ST_OK;
    end
  end

  assign out_valid  = vld_r[LAT-1];
  assign out_rx     = rx_r;
  assign out_ry     = ry_r;
  assign out_rz     = rz_r;
  assign out_length = len_r;
  assign out_status = st_r;

  `V3A_ASSERT_DLY(a_latency, start && !busy, LAT, out_valid)
  `V3A_ASSERT_IMP(a_zero_norm, out_valid && out_status == ST_ZERO,
                  out_length == '0 && out_rx == '0 && out_ry == '0 && out_rz == '0)

endmodule
`default_nettype wire
